// ===== hw/rtl/rbsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsc_pkg
// Shared types and constants for the rank-by-smaller-count unit.
// ----------------------------------------------------------------------------
package rbsc_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 6;

  // One input request: a value and the end-of-set mark
  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      last_item;
  } item_t;

  // One result: rank of a stored value and the end-of-results mark
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              last_rank;
  } result_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_KEY,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic store;      // write the request value, bump the count
    logic rank_init;  // clear the outer index
    logic fetch;      // read the entry under rank, clear the tally
    logic key_load;   // latch the key, read entry zero
    logic scan;       // tally one compare, read the next entry
    logic emit;       // register a result, step or end the pass
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;  // every stored entry has been compared
    logic last_entry; // outer index is at the final stored value
  } status_t;

endpackage

// ===== hw/rtl/rbsc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsc_ctrl
// Sequencer: loads requests, then runs one compare sweep per stored value.
// ----------------------------------------------------------------------------
module rbsc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             last_item,
  input  rbsc_pkg::status_t status,
  output rbsc_pkg::cmd_t    cmd,
  output logic             busy
);
  import rbsc_pkg::*;

  state_t state;
  state_t state_next;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Select the next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && last_item) state_next = ST_FETCH;
      end
      ST_FETCH: state_next = ST_KEY;
      ST_KEY:   state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        state_next = status.last_entry ? ST_IDLE : ST_FETCH;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.store     = start;
        cmd.rank_init = start && last_item;
      end
      ST_FETCH: cmd.fetch    = 1'b1;
      ST_KEY:   cmd.key_load = 1'b1;
      ST_SCAN:  cmd.scan     = !status.scan_done;
      ST_EMIT:  cmd.emit     = 1'b1;
      default:  cmd          = '0;
    endcase
  end

endmodule

// ===== hw/rtl/rbsc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsc_datapath
// Value memory, count, sweep indexes, compare tally and result register.
// ----------------------------------------------------------------------------
module rbsc_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  rbsc_pkg::cmd_t    cmd,
  input  rbsc_pkg::item_t   item,
  output rbsc_pkg::status_t status,
  output logic              result_valid,
  output rbsc_pkg::result_t result
);
  import rbsc_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic signed [VALUE_W-1:0] mem [CAPACITY];
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] key;
  logic [IDX_W-1:0]          rd_addr;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          j;
  logic [CNT_W-1:0]          tally;
  logic [IDX_W-1:0]          i;
  logic                      room;

  assign room              = (count != CNT_W'(CAPACITY));
  assign status.scan_done  = (j == count);
  assign status.last_entry = ((CNT_W'(i) + CNT_W'(1)) == count);

  // Pick the read address: outer entry on fetch, entry zero on key load,
  // otherwise the entry after the one being compared
  always_comb begin
    priority if (cmd.fetch) begin
      rd_addr = i;
    end else if (cmd.key_load) begin
      rd_addr = '0;
    end else begin
      rd_addr = j[IDX_W-1:0] + IDX_W'(1);
    end
  end

  // Write a request value while there is room; register the read
  always_ff @(posedge clk) begin
    if (cmd.store && room) begin
      mem[count[IDX_W-1:0]] <= item.sample_value;
    end
    rd_data <= mem[rd_addr];
  end

  // Advance the count and the outer index
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      i     <= '0;
    end else begin
      if (cmd.store && room) count <= count + CNT_W'(1);
      if (cmd.rank_init) i <= '0;
      if (cmd.emit) begin
        if (status.last_entry) count <= '0;
        else                   i     <= i + IDX_W'(1);
      end
    end
  end

  // Sweep the entries and tally the smaller ones; j counts compared entries
  always_ff @(posedge clk) begin
    if (rst) begin
      j     <= '0;
      tally <= '0;
    end else begin
      if (cmd.fetch) begin
        tally <= '0;
        j     <= '0;
      end
      if (cmd.key_load) j <= '0;
      if (cmd.scan) begin
        j <= j + CNT_W'(1);
        if (rd_data < key) tally <= tally + CNT_W'(1);
      end
    end
  end

  // Latch the key of the current outer entry
  always_ff @(posedge clk) begin
    if (cmd.key_load) key <= rd_data;
  end

  // Register one result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.rank      <= RANK_W'(tally);
      result.last_rank <= status.last_entry;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("stored count exceeds capacity");

  a_tally_bound: assert property (@(posedge clk) disable iff (rst)
    tally <= j)
    else $error("tally exceeds compared entries");

  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(cmd.emit))
    else $error("result strobe without emit");

  a_set_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last_entry) |=> (count == '0))
    else $error("set not emptied after final result");
`endif

endmodule

// ===== hw/rtl/rank_by_smaller_count_unit.sv =====
`timescale 1ns / 1ps
// Operation: a non-final request is stored while busy stays low.
// On the final request, the controller ranks each stored value in turn: it
// fetches the value, latches it as the key, then sweeps every stored value
// through the one memory read port and emits one result per sweep. Busy stays
// high until the last result appears. Results are one-cycle strobes.
// Reset clears the count and controller; stored values are not cleared.
// ----------------------------------------------------------------------------
// rank_by_smaller_count_unit
// Ranks each loaded value by how many stored values are strictly smaller.
// ----------------------------------------------------------------------------
module rank_by_smaller_count_unit #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rbsc_pkg::item_t   item,
  output logic              result_valid,
  output rbsc_pkg::result_t result
);
  import rbsc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence loading and ranking
  rbsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_item (item.last_item),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Store values and count smaller ones
  rbsc_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
